// ===== hdl/jkse_pkg.sv =====
// Shared types, phase codes and the per-byte parse step of the JSON key string extractor.
// Used by jkse_stack and json_key_string_extractor; depends on nothing else.
package jkse_pkg;

  localparam int DEPTH_W = 7;
  localparam int NEST_DEPTH_DEF = 16;
  localparam int KEY_MAX_DEF = 16;
  localparam int VALUE_MAX_DEF = 4096;

  localparam logic [4:0] PH_OPEN   = 5'd0;
  localparam logic [4:0] PH_KSTART = 5'd1;
  localparam logic [4:0] PH_KEY    = 5'd2;
  localparam logic [4:0] PH_COLM   = 5'd3;
  localparam logic [4:0] PH_VSTART = 5'd4;
  localparam logic [4:0] PH_VALUE  = 5'd5;
  localparam logic [4:0] PH_COLS   = 5'd6;
  localparam logic [4:0] PH_AFTS   = 5'd7;
  localparam logic [4:0] PH_OCOLON = 5'd8;
  localparam logic [4:0] PH_OAFTER = 5'd9;
  localparam logic [4:0] PH_AAFTER = 5'd10;
  localparam logic [4:0] PH_VS     = 5'd12;
  localparam logic [4:0] PH_LSTR   = 5'd16;
  localparam logic [4:0] PH_LNUM   = 5'd20;
  localparam logic [4:0] PH_LLIT   = 5'd24;

  localparam logic [2:0] GRP_VS   = 3'd3;
  localparam logic [2:0] GRP_LSTR = 3'd4;
  localparam logic [2:0] GRP_LNUM = 3'd5;
  localparam logic [2:0] GRP_LLIT = 3'd6;

  localparam logic [1:0] R_TOP  = 2'd0;
  localparam logic [1:0] R_OKEY = 2'd1;
  localparam logic [1:0] R_OVAL = 2'd2;
  localparam logic [1:0] R_AEL  = 2'd3;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_LIMIT  = 3'd1;
  localparam logic [2:0] ST_ENDED  = 3'd2;
  localparam logic [2:0] ST_NOKEY  = 3'd3;
  localparam logic [2:0] ST_NOTSTR = 3'd4;
  localparam logic [2:0] ST_NEST   = 3'd5;

  localparam logic [1:0] CFG_KEY_LEN = 2'd0;
  localparam logic [1:0] CFG_KEY_LO  = 2'd1;
  localparam logic [1:0] CFG_KEY_HI  = 2'd2;
  localparam logic [1:0] CFG_MAX_LEN = 2'd3;

  localparam logic [2:0] NUM_INT  = 3'd1;
  localparam logic [2:0] NUM_FRAC = 3'd2;
  localparam logic [2:0] NUM_ESGN = 3'd3;
  localparam logic [2:0] NUM_EXP  = 3'd4;

  typedef struct packed {
    logic [4:0]         phase;
    logic [DEPTH_W-1:0] depth;
    logic [4:0]         kidx;
    logic               kmatch;
    logic               esc;
    logic [2:0]         lit;
    logic [2:0]         num;
    logic [11:0]        cnt;
    logic               fin;
  } st_t;

  typedef struct packed {
    st_t        st;
    logic       cont;
    logic       push;
    logic [1:0] push_val;
    logic       pop;
    logic       emit;
    logic [7:0] ch;
    logic       done;
    logic [2:0] status;
  } step_t;

  function automatic logic is_ws(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0d || c == 8'h0a;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic [4:0] after_of(input logic [1:0] r);
    logic [4:0] p;
    case (r)
      R_TOP:   p = PH_AFTS;
      R_OKEY:  p = PH_OCOLON;
      R_OVAL:  p = PH_OAFTER;
      default: p = PH_AAFTER;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] unescape(input logic [7:0] c);
    logic [7:0] u;
    case (c)
      8'h62:   u = 8'd8;
      8'h66:   u = 8'd12;
      8'h6e:   u = 8'd10;
      8'h72:   u = 8'd13;
      8'h74:   u = 8'd9;
      8'h75:   u = 8'h3f;
      default: u = c;
    endcase
    return u;
  endfunction

  function automatic step_t jkse_step(input st_t s, input logic [7:0] c, input logic [1:0] top,
                                      input logic [127:0] key, input logic [4:0] klen,
                                      input logic [11:0] lim, input logic full);
    step_t      o;
    logic [4:0] ph;
    logic [1:0] r;
    logic [12:0] cnt1;
    logic       do_emit;
    logic [7:0] ech;
    logic       do_kc;
    logic       do_pop;
    logic       nok;
    o = '0;
    o.st = s;
    ph = s.phase;
    r = ph[1:0];
    cnt1 = {1'b0, s.cnt} + 13'd1;
    do_emit = 1'b0;
    ech = c;
    do_kc = 1'b0;
    do_pop = 1'b0;
    nok = 1'b1;
    if (ph[4:2] == GRP_VS) begin
      if (!is_ws(c)) begin
        if (c == 8'h22) begin
          o.st.esc = 1'b0;
          o.st.phase = PH_LSTR + {3'd0, r};
        end else if (c == 8'h7b || c == 8'h5b) begin
          if (full) begin
            o.st.fin = 1'b1;
            o.done = 1'b1;
            o.status = ST_NEST;
          end else begin
            o.push = 1'b1;
            o.push_val = r;
            o.st.depth = s.depth + DEPTH_W'(1);
            o.st.phase = PH_VS + ((c == 8'h7b) ? {3'd0, R_OKEY} : {3'd0, R_AEL});
          end
        end else if (c == 8'h2d || is_digit(c)) begin
          o.st.num = NUM_INT;
          o.st.phase = PH_LNUM + {3'd0, r};
        end else if (c == 8'h74 || c == 8'h6e) begin
          o.st.lit = 3'd3;
          o.st.phase = PH_LLIT + {3'd0, r};
        end else if (c == 8'h66) begin
          o.st.lit = 3'd4;
          o.st.phase = PH_LLIT + {3'd0, r};
        end else begin
          o.st.phase = after_of(r);
          o.cont = 1'b1;
        end
      end
    end else if (ph[4:2] == GRP_LSTR) begin
      if (s.esc) begin
        o.st.esc = 1'b0;
      end else if (c == 8'h5c) begin
        o.st.esc = 1'b1;
      end else if (c == 8'h22) begin
        o.st.phase = after_of(r);
      end
    end else if (ph[4:2] == GRP_LNUM) begin
      case (s.num)
        NUM_INT: begin
          if (is_digit(c)) begin
            nok = 1'b0;
          end else if (c == 8'h2e) begin
            o.st.num = NUM_FRAC;
            nok = 1'b0;
          end else if (c == 8'h65 || c == 8'h45) begin
            o.st.num = NUM_ESGN;
            nok = 1'b0;
          end
        end
        NUM_FRAC: begin
          if (is_digit(c)) begin
            nok = 1'b0;
          end else if (c == 8'h65 || c == 8'h45) begin
            o.st.num = NUM_ESGN;
            nok = 1'b0;
          end
        end
        NUM_ESGN: begin
          if (c == 8'h2b || c == 8'h2d || is_digit(c)) begin
            o.st.num = NUM_EXP;
            nok = 1'b0;
          end
        end
        NUM_EXP: begin
          if (is_digit(c)) nok = 1'b0;
        end
        default: begin
          nok = 1'b1;
        end
      endcase
      if (nok) begin
        o.st.num = 3'd0;
        o.st.phase = after_of(r);
        o.cont = 1'b1;
      end
    end else if (ph[4:2] == GRP_LLIT) begin
      if (s.lit > 3'd1) begin
        o.st.lit = s.lit - 3'd1;
      end else begin
        o.st.lit = 3'd0;
        o.st.phase = after_of(r);
      end
    end else begin
      case (ph)
        PH_OPEN: begin
          if (!is_ws(c)) begin
            if (c == 8'h7b) begin
              o.st.phase = PH_KSTART;
            end else begin
              o.st.fin = 1'b1;
              o.done = 1'b1;
              o.status = ST_NOKEY;
            end
          end
        end
        PH_KSTART: begin
          if (!is_ws(c)) begin
            if (c == 8'h22) begin
              o.st.phase = PH_KEY;
              o.st.kidx = 5'd0;
              o.st.kmatch = 1'b1;
              o.st.esc = 1'b0;
            end else begin
              o.st.fin = 1'b1;
              o.done = 1'b1;
              o.status = ST_NOKEY;
            end
          end
        end
        PH_KEY: begin
          if (s.esc) begin
            o.st.esc = 1'b0;
            do_kc = 1'b1;
          end else if (c == 8'h22) begin
            o.st.phase = (s.kmatch && s.kidx == klen) ? PH_COLM : PH_COLS;
          end else begin
            if (c == 8'h5c) o.st.esc = 1'b1;
            do_kc = 1'b1;
          end
        end
        PH_COLM: begin
          if (!is_ws(c)) begin
            o.st.phase = PH_VSTART;
            o.cont = c != 8'h3a;
          end
        end
        PH_VSTART: begin
          if (!is_ws(c)) begin
            if (c == 8'h22) begin
              o.st.phase = PH_VALUE;
              o.st.esc = 1'b0;
              o.st.lit = 3'd0;
              if (lim == 12'd0) begin
                o.st.fin = 1'b1;
                o.done = 1'b1;
                o.status = ST_LIMIT;
              end
            end else begin
              o.st.fin = 1'b1;
              o.done = 1'b1;
              o.status = ST_NOTSTR;
            end
          end
        end
        PH_VALUE: begin
          if (s.lit != 3'd0) begin
            o.st.lit = s.lit - 3'd1;
          end else if (s.esc) begin
            o.st.esc = 1'b0;
            if (c == 8'h75) o.st.lit = 3'd4;
            ech = unescape(c);
            do_emit = 1'b1;
          end else if (c == 8'h5c) begin
            o.st.esc = 1'b1;
          end else if (c == 8'h22) begin
            o.st.fin = 1'b1;
            o.done = 1'b1;
            o.status = ST_OK;
          end else begin
            do_emit = 1'b1;
          end
        end
        PH_COLS: begin
          if (!is_ws(c)) begin
            o.st.phase = PH_VS + {3'd0, R_TOP};
            o.cont = c != 8'h3a;
          end
        end
        PH_AFTS: begin
          if (!is_ws(c)) begin
            o.st.phase = PH_KSTART;
            o.cont = c != 8'h2c;
          end
        end
        PH_OCOLON: begin
          if (!is_ws(c)) begin
            o.st.phase = PH_VS + {3'd0, R_OVAL};
            o.cont = c != 8'h3a;
          end
        end
        PH_OAFTER: begin
          if (!is_ws(c)) begin
            if (c == 8'h2c) begin
              o.st.phase = PH_VS + {3'd0, R_OKEY};
            end else begin
              do_pop = 1'b1;
              o.cont = c != 8'h7d;
            end
          end
        end
        PH_AAFTER: begin
          if (!is_ws(c)) begin
            if (c == 8'h2c) begin
              o.st.phase = PH_VS + {3'd0, R_AEL};
            end else begin
              do_pop = 1'b1;
              o.cont = c != 8'h5d;
            end
          end
        end
        default: begin
          o.st.fin = 1'b1;
          o.done = 1'b1;
          o.status = ST_NOKEY;
        end
      endcase
    end
    if (do_kc) begin
      if (!(s.kidx < klen && c == key[{s.kidx[3:0], 3'b000} +: 8])) o.st.kmatch = 1'b0;
      if (s.kidx != 5'd31) o.st.kidx = s.kidx + 5'd1;
    end
    if (do_pop) begin
      if (s.depth == '0) begin
        o.st.phase = PH_AFTS;
      end else begin
        o.pop = 1'b1;
        o.st.depth = s.depth - DEPTH_W'(1);
        o.st.phase = after_of(top);
      end
    end
    if (do_emit) begin
      o.emit = 1'b1;
      o.ch = ech;
      o.st.cnt = cnt1[11:0];
      if (cnt1 >= {1'b0, lim}) begin
        o.st.fin = 1'b1;
        o.done = 1'b1;
        o.status = ST_LIMIT;
      end
    end
    return o;
  endfunction

endpackage

// ===== hdl/jkse_stack.sv =====
// Container return-context stack of the JSON key string extractor, kept in flip-flops.
// Depends on jkse_pkg for the default depth.
module jkse_stack #(
  parameter int NEST_DEPTH = jkse_pkg::NEST_DEPTH_DEF,
  localparam int IDX_W = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  logic [1:0]       wr_val,
  input  logic [IDX_W-1:0] rd_idx,
  output logic [1:0]       rd_val
);

  logic [1:0] ctx_r [NEST_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ctx_r[wr_idx] <= wr_val;
    end
  end

  assign rd_val = ctx_r[rd_idx];

endmodule

// ===== hdl/json_key_string_extractor.sv =====
// The input byte is registered, and its result is registered again at the output.
// Throughput: one byte per cycle unless the output stalls; a byte that runs into a container
// close after an unexpected byte or needs over two parse steps holds the input for those steps.
// Reset: synchronous active-low; parser rearmed, configuration back to its reset values.
// Depends on jkse_pkg and jkse_stack.
module json_key_string_extractor #(
  parameter int NEST_DEPTH = jkse_pkg::NEST_DEPTH_DEF,
  parameter int KEY_MAX    = jkse_pkg::KEY_MAX_DEF,
  parameter int VALUE_MAX  = jkse_pkg::VALUE_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_value_byte,
  output logic        out_value_valid,
  output logic        out_done_res,
  output logic [2:0]  out_status,
  output logic [11:0] out_value_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int IDX_W = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
  localparam int CAP = (VALUE_MAX < 4096) ? VALUE_MAX : 4096;
  localparam logic [12:0] CAP13 = 13'(CAP);
  localparam logic [4:0] KMAX5 = 5'(KEY_MAX);
  localparam logic [jkse_pkg::DEPTH_W-1:0] NDEPTH = jkse_pkg::DEPTH_W'(NEST_DEPTH);

  logic [4:0]  key_length_r;
  logic [63:0] key_lo_r;
  logic [63:0] key_hi_r;
  logic [12:0] max_len_r;

  logic       inv_r;
  logic [7:0] inb_r;
  logic       inl_r;

  jkse_pkg::st_t st_r, st_nxt, st_rst;
  jkse_pkg::step_t sa, sb, sel;

  logic        outv_r;
  logic [7:0]  ob_r;
  logic        ovv_r;
  logic        od_r;
  logic [2:0]  os_r;
  logic [11:0] ol_r;

  logic [4:0]   klen;
  logic [12:0]  effm;
  logic [11:0]  lim;
  logic [127:0] key;
  logic         full;
  logic [1:0]   top;
  logic         final_c;
  logic         advance;
  logic         update;
  logic         res_done;
  logic [2:0]   res_status;

  assign klen = (key_length_r > KMAX5) ? KMAX5 : key_length_r;
  assign effm = (max_len_r > CAP13) ? CAP13 : max_len_r;
  assign lim = (effm == 13'd0) ? 12'd0 : 12'(effm - 13'd1);
  assign key = {key_hi_r, key_lo_r};
  assign full = st_r.depth >= NDEPTH;
  assign cfg_ready = 1'b1;

  always_comb begin
    st_rst = '0;
    st_rst.phase = jkse_pkg::PH_OPEN;
    st_rst.kmatch = 1'b1;
  end

  jkse_stack #(.NEST_DEPTH(NEST_DEPTH)) u_stack (
    .clk    (clk),
    .wr_en  (update && sel.push),
    .wr_idx (st_r.depth[IDX_W-1:0]),
    .wr_val (sel.push_val),
    .rd_idx (IDX_W'(st_r.depth - jkse_pkg::DEPTH_W'(1))),
    .rd_val (top)
  );

  always_comb begin
    sa = jkse_pkg::jkse_step(st_r, inb_r, top, key, klen, lim, full);
    sb = jkse_pkg::jkse_step(sa.st, inb_r, top, key, klen, lim, full);
    if (st_r.fin) begin
      sel = '0;
      sel.st = st_r;
    end else if (sa.cont && !sa.push && !sa.pop) begin
      sel = sb;
    end else begin
      sel = sa;
    end
    final_c = !sel.cont;
    advance = inv_r && final_c && (!outv_r || out_ready);
    update = inv_r && (!final_c || advance);
    in_ready = !inv_r || advance;
    res_done = sel.done;
    res_status = sel.status;
    if (inl_r && !sel.st.fin) begin
      res_done = 1'b1;
      if (sel.st.phase == jkse_pkg::PH_VALUE) begin
        res_status = jkse_pkg::ST_ENDED;
      end else if (sel.st.phase == jkse_pkg::PH_COLM || sel.st.phase == jkse_pkg::PH_VSTART) begin
        res_status = jkse_pkg::ST_NOTSTR;
      end else begin
        res_status = jkse_pkg::ST_NOKEY;
      end
    end
    st_nxt = sel.st;
    if (final_c && inl_r) begin
      st_nxt = st_rst;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r <= 5'd0;
      key_lo_r <= 64'd0;
      key_hi_r <= 64'd0;
      max_len_r <= 13'd256;
      inv_r <= 1'b0;
      st_r <= st_rst;
      outv_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          jkse_pkg::CFG_KEY_LEN: key_length_r <= cfg_data[4:0];
          jkse_pkg::CFG_KEY_LO:  key_lo_r <= cfg_data;
          jkse_pkg::CFG_KEY_HI:  key_hi_r <= cfg_data;
          jkse_pkg::CFG_MAX_LEN: max_len_r <= cfg_data[12:0];
          default: key_length_r <= key_length_r;
        endcase
      end
      if (in_ready) begin
        inv_r <= in_valid;
      end
      if (update) begin
        st_r <= st_nxt;
      end
      if (advance) begin
        outv_r <= sel.emit || res_done;
      end else if (out_ready) begin
        outv_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      inb_r <= in_byte;
      inl_r <= in_last_byte;
    end
    if (advance) begin
      ob_r <= sel.emit ? sel.ch : 8'd0;
      ovv_r <= sel.emit;
      od_r <= res_done;
      os_r <= res_done ? res_status : 3'd0;
      ol_r <= res_done ? sel.st.cnt : 12'd0;
    end
  end

  assign out_valid = outv_r;
  assign out_value_byte = ob_r;
  assign out_value_valid = ovv_r;
  assign out_done_res = od_r;
  assign out_status = os_r;
  assign out_value_length = ol_r;

  a_res_has_content: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_value_valid || out_done_res))
    else $error("result without character or done");

  a_status_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_done_res) |-> (out_status == jkse_pkg::ST_OK))
    else $error("status set without done");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.depth <= NDEPTH)
    else $error("nesting depth beyond stack");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.cnt <= lim) || (lim == 12'd0 && st_r.cnt == 12'd0))
    else $error("emitted count beyond limit");

endmodule
